// ===== rtl/conservative_to_primitive_top_assert.svh =====
// Assertion macros used by the top-level RTL file.
`ifndef CONSERVATIVE_TO_PRIMITIVE_TOP_ASSERT_SVH
`define CONSERVATIVE_TO_PRIMITIVE_TOP_ASSERT_SVH

// Check that a implies b in the same cycle.
`define CTP_ASSERT_IMPL(lbl, clk, rst, a, b) \
   lbl: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
      else $error("implication check failed");

// Check that a implies b after the delay given by argument n.
`define CTP_ASSERT_DELAY(lbl, clk, rst, a, n, b) \
   lbl: assert property (@(posedge clk) disable iff (rst) (a) |-> ##n (b)) \
      else $error("delayed implication check failed");

`endif

// ===== rtl/ctp_pkg.sv =====
package ctp_pkg;

   localparam int DATA_W  = 32;
   localparam int FRAC_W  = 16;
   localparam int RHO_W   = DATA_W - 1;
   localparam int DEN_W   = 2 * RHO_W;
   localparam int SQ_W    = DATA_W + FRAC_W;
   localparam int GAMMA_W = 18;
   localparam int COEF_W  = 31;
   localparam int FLOOR_W = 17;

   localparam int VEL_DIV_LAT  = DATA_W + 1;
   localparam int TEMP_DIV_LAT = RHO_W + 1;
   localparam int PRESS_LAT    = 8;
   localparam int RSP_LAT      = 1 + VEL_DIV_LAT + PRESS_LAT + TEMP_DIV_LAT + 1;

   localparam logic [RHO_W-1:0]   SMAX = '1;
   localparam logic [GAMMA_W-1:0] ONE_Q = GAMMA_W'(1) << FRAC_W;

   localparam logic [GAMMA_W-1:0] GAMMA_RST  = GAMMA_W'(109227);
   localparam logic [COEF_W-1:0]  COEF_RST   = COEF_W'(65536);
   localparam logic [FLOOR_W-1:0] DFLOOR_RST = FLOOR_W'(1);
   localparam logic [FLOOR_W-1:0] PFLOOR_RST = FLOOR_W'(1);

   typedef enum logic [1:0] {
      CSR_GAMMA,
      CSR_COEF,
      CSR_DFLOOR,
      CSR_PFLOOR
   } csr_index_type;

   typedef struct packed {
      logic [GAMMA_W-1:0] gamma;
      logic [COEF_W-1:0]  coef;
      logic [FLOOR_W-1:0] dfloor;
      logic [FLOOR_W-1:0] pfloor;
   } csr_type;

   typedef struct packed {
      logic [2:0][DATA_W-1:0] vel;
      logic [RHO_W-1:0]       rho;
      logic [DATA_W-1:0]      energy;
   } cell_type;

   typedef struct packed {
      logic [2:0][DATA_W-1:0] vel;
      logic [RHO_W-1:0]       pressure;
      logic [DEN_W-1:0]       den;
   } prim_type;

endpackage

// ===== rtl/conservative_to_primitive_top.sv =====
// Conservative to primitive conversion for one fluid cell, signed Q16.16.
// Request channel: drive start high with req_density, req_momentum_x/y/z
// and req_total_energy; the cell is taken at a clock edge where start is
// high and busy is low. busy is low at all times outside reset once it has
// first fallen, so one cell may be offered on every cycle.
// Result channel: rsp_strobe is high for exactly one cycle together with
// rsp_velocity_x/y/z, rsp_pressure and rsp_temperature. The receiver must
// take each result in that cycle; there is no way to hold results off.
// Throughput is one cell per cycle. A cell passes through the bit-per-stage
// dividers, with 32 stages for the velocity quotients and 31 stages for the
// temperature quotient, and through the squaring, kinetic energy, pressure
// and output registers.
// Configuration: csr_valid with csr_index and csr_wdata writes one register
// (gamma ratio, state coefficient, density floor, pressure floor); csr_ready
// is always high. Write only while no cell is in flight.
// Reset (synchronous, active high) clears all in-flight cells, restores the
// register defaults and holds busy high through the cycle after reset.
module conservative_to_primitive_top (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   output logic                       busy,
   input  logic signed [31:0]         req_density,
   input  logic signed [31:0]         req_momentum_x,
   input  logic signed [31:0]         req_momentum_y,
   input  logic signed [31:0]         req_momentum_z,
   input  logic signed [31:0]         req_total_energy,
   output logic                       rsp_strobe,
   output logic signed [31:0]         rsp_velocity_x,
   output logic signed [31:0]         rsp_velocity_y,
   output logic signed [31:0]         rsp_velocity_z,
   output logic [30:0]                rsp_pressure,
   output logic [30:0]                rsp_temperature,
   input  logic                       csr_valid,
   output logic                       csr_ready,
   input  ctp_pkg::csr_index_type     csr_index,
   input  logic [31:0]                csr_wdata
);
   import ctp_pkg::*;

`include "conservative_to_primitive_top_assert.svh"

   localparam int TAG_W = 3 * DATA_W + RHO_W;

   logic         busy_ff;
   csr_type      csr_ff;
   logic         req_accept;

   logic         vel_valid_w;
   cell_type     vel_cell_w;
   logic         prim_valid_w;
   prim_type     prim_w;

   logic               tdiv_valid_w;
   logic [RHO_W-1:0]   tdiv_quo_w;
   logic               tdiv_ovf_w;
   logic [TAG_W-1:0]   tdiv_tag_w;

   logic               rsp_strobe_ff;
   logic [2:0][DATA_W-1:0] rsp_vel_ff;
   logic [RHO_W-1:0]   rsp_pressure_ff;
   logic [RHO_W-1:0]   rsp_temperature_ff;

   assign req_accept = start & ~busy_ff;
   assign busy       = busy_ff;
   assign csr_ready  = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff       <= 1'b1;
         csr_ff.gamma  <= GAMMA_RST;
         csr_ff.coef   <= COEF_RST;
         csr_ff.dfloor <= DFLOOR_RST;
         csr_ff.pfloor <= PFLOOR_RST;
      end else begin
         busy_ff <= 1'b0;
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_GAMMA:  csr_ff.gamma  <= csr_wdata[GAMMA_W-1:0];
               CSR_COEF:   csr_ff.coef   <= csr_wdata[COEF_W-1:0];
               CSR_DFLOOR: csr_ff.dfloor <= csr_wdata[FLOOR_W-1:0];
               CSR_PFLOOR: csr_ff.pfloor <= csr_wdata[FLOOR_W-1:0];
               default: begin
               end
            endcase
         end
      end
   end

   ctp_velocity u_velocity (
      .clock        (clock),
      .reset        (reset),
      .in_valid     (req_accept),
      .density      (req_density),
      .momentum_x   (req_momentum_x),
      .momentum_y   (req_momentum_y),
      .momentum_z   (req_momentum_z),
      .total_energy (req_total_energy),
      .csr          (csr_ff),
      .out_valid    (vel_valid_w),
      .out_cell     (vel_cell_w)
   );

   ctp_pressure u_pressure (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (vel_valid_w),
      .in_cell   (vel_cell_w),
      .csr       (csr_ff),
      .out_valid (prim_valid_w),
      .out_prim  (prim_w)
   );

   ctp_div_pipe #(
      .NUM_W (RHO_W + DATA_W),
      .DEN_W (DEN_W),
      .QUO_W (RHO_W),
      .TAG_W (TAG_W)
   ) u_temp_div (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (prim_valid_w),
      .in_num    ({prim_w.pressure, {DATA_W{1'b0}}}),
      .in_den    (prim_w.den),
      .in_tag    ({prim_w.vel, prim_w.pressure}),
      .out_valid (tdiv_valid_w),
      .out_quo   (tdiv_quo_w),
      .out_ovf   (tdiv_ovf_w),
      .out_tag   (tdiv_tag_w)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= tdiv_valid_w;
      end
      rsp_vel_ff         <= tdiv_tag_w[TAG_W-1:RHO_W];
      rsp_pressure_ff    <= tdiv_tag_w[RHO_W-1:0];
      rsp_temperature_ff <= tdiv_ovf_w ? SMAX : tdiv_quo_w;
   end

   assign rsp_strobe      = rsp_strobe_ff;
   assign rsp_velocity_x  = rsp_vel_ff[0];
   assign rsp_velocity_y  = rsp_vel_ff[1];
   assign rsp_velocity_z  = rsp_vel_ff[2];
   assign rsp_pressure    = rsp_pressure_ff;
   assign rsp_temperature = rsp_temperature_ff;

   `CTP_ASSERT_IMPL(a_rsp_from_req, clock, reset, rsp_strobe, $past(req_accept, RSP_LAT))
   `CTP_ASSERT_DELAY(a_req_gives_rsp, clock, reset, req_accept, RSP_LAT, rsp_strobe)
   `CTP_ASSERT_IMPL(a_busy_after_reset, clock, reset, $past(reset), busy)

endmodule

// ===== rtl/ctp_div_pipe.sv =====
module ctp_div_pipe #(
   parameter int NUM_W = 48,
   parameter int DEN_W = 31,
   parameter int QUO_W = 32,
   parameter int TAG_W = 1
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   input  logic [NUM_W-1:0] in_num,
   input  logic [DEN_W-1:0] in_den,
   input  logic [TAG_W-1:0] in_tag,
   output logic             out_valid,
   output logic [QUO_W-1:0] out_quo,
   output logic             out_ovf,
   output logic [TAG_W-1:0] out_tag
);

   logic             valid_ff [0:QUO_W];
   logic [DEN_W-1:0] rem_ff   [0:QUO_W];
   logic [QUO_W-1:0] low_ff   [0:QUO_W];
   logic [DEN_W-1:0] den_ff   [0:QUO_W];
   logic             ovf_ff   [0:QUO_W];
   logic [TAG_W-1:0] tag_ff   [0:QUO_W];
   logic [DEN_W-1:0] hi_w;

   assign hi_w = DEN_W'(in_num[NUM_W-1:QUO_W]);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff[0] <= 1'b0;
      end else begin
         valid_ff[0] <= in_valid;
      end
      rem_ff[0] <= hi_w;
      low_ff[0] <= in_num[QUO_W-1:0];
      den_ff[0] <= in_den;
      ovf_ff[0] <= (hi_w >= in_den);
      tag_ff[0] <= in_tag;
   end

   for (genvar k = 1; k <= QUO_W; k++) begin : g_step
      logic [DEN_W:0]   shift_w;
      logic [DEN_W:0]   diff_w;
      logic [DEN_W-1:0] rem_in;
      logic [QUO_W-1:0] low_in;

      assign shift_w = {rem_ff[k-1], low_ff[k-1][QUO_W-1]};
      assign diff_w  = shift_w - {1'b0, den_ff[k-1]};
      assign rem_in  = diff_w[DEN_W] ? shift_w[DEN_W-1:0] : diff_w[DEN_W-1:0];
      assign low_in  = {low_ff[k-1][QUO_W-2:0], ~diff_w[DEN_W]};

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[k] <= 1'b0;
         end else begin
            valid_ff[k] <= valid_ff[k-1];
         end
         rem_ff[k] <= rem_in;
         low_ff[k] <= low_in;
         den_ff[k] <= den_ff[k-1];
         ovf_ff[k] <= ovf_ff[k-1];
         tag_ff[k] <= tag_ff[k-1];
      end
   end

   assign out_valid = valid_ff[QUO_W];
   assign out_quo   = low_ff[QUO_W];
   assign out_ovf   = ovf_ff[QUO_W];
   assign out_tag   = tag_ff[QUO_W];

endmodule

// ===== rtl/ctp_velocity.sv =====
module ctp_velocity (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   input  logic signed [31:0]    density,
   input  logic signed [31:0]    momentum_x,
   input  logic signed [31:0]    momentum_y,
   input  logic signed [31:0]    momentum_z,
   input  logic signed [31:0]    total_energy,
   input  ctp_pkg::csr_type      csr,
   output logic                  out_valid,
   output ctp_pkg::cell_type     out_cell
);
   import ctp_pkg::*;

   localparam int SIDE_W = RHO_W + DATA_W;

   logic [FLOOR_W-1:0]     dfloor_w;
   logic [RHO_W-1:0]       rho_w;
   logic [2:0][DATA_W-1:0] mom_w;

   logic                   a_valid_ff;
   logic [RHO_W-1:0]       a_rho_ff;
   logic [DATA_W-1:0]      a_energy_ff;
   logic [2:0][DATA_W-1:0] a_mag_ff;
   logic [2:0]             a_neg_ff;

   logic [2:0]             div_valid_w;
   logic [2:0][DATA_W-1:0] div_quo_w;
   logic [2:0]             div_ovf_w;
   logic [2:0]             div_neg_w;
   logic [SIDE_W-1:0]      side_ff [0:VEL_DIV_LAT-1];

   logic                   b_valid_ff;
   cell_type               b_cell_ff;
   logic [2:0][DATA_W-1:0] vel_in;

   assign dfloor_w = (csr.dfloor == '0) ? FLOOR_W'(1) : csr.dfloor;
   assign rho_w    = (density > $signed({{(DATA_W-FLOOR_W){1'b0}}, dfloor_w}))
                     ? density[RHO_W-1:0] : RHO_W'(dfloor_w);
   assign mom_w    = {momentum_z, momentum_y, momentum_x};

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else begin
         a_valid_ff <= in_valid;
      end
      a_rho_ff    <= rho_w;
      a_energy_ff <= total_energy;
      for (int i = 0; i < 3; i++) begin
         a_neg_ff[i] <= mom_w[i][DATA_W-1];
         a_mag_ff[i] <= mom_w[i][DATA_W-1] ? (~mom_w[i] + DATA_W'(1)) : mom_w[i];
      end
   end

   for (genvar i = 0; i < 3; i++) begin : g_lane
      ctp_div_pipe #(
         .NUM_W (SQ_W),
         .DEN_W (RHO_W),
         .QUO_W (DATA_W),
         .TAG_W (1)
      ) u_div (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (a_valid_ff),
         .in_num    ({a_mag_ff[i], {FRAC_W{1'b0}}}),
         .in_den    (a_rho_ff),
         .in_tag    (a_neg_ff[i]),
         .out_valid (div_valid_w[i]),
         .out_quo   (div_quo_w[i]),
         .out_ovf   (div_ovf_w[i]),
         .out_tag   (div_neg_w[i])
      );
   end

   always_ff @(posedge clock) begin
      side_ff[0] <= {a_rho_ff, a_energy_ff};
      for (int k = 1; k < VEL_DIV_LAT; k++) begin
         side_ff[k] <= side_ff[k-1];
      end
   end

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         if (div_neg_w[i]) begin
            if (div_ovf_w[i] || (div_quo_w[i] > {1'b1, {RHO_W{1'b0}}})) begin
               vel_in[i] = {1'b1, {RHO_W{1'b0}}};
            end else begin
               vel_in[i] = ~div_quo_w[i] + DATA_W'(1);
            end
         end else begin
            if (div_ovf_w[i] || div_quo_w[i][DATA_W-1]) begin
               vel_in[i] = {1'b0, SMAX};
            end else begin
               vel_in[i] = div_quo_w[i];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff <= 1'b0;
      end else begin
         b_valid_ff <= div_valid_w[0];
      end
      b_cell_ff.vel    <= vel_in;
      b_cell_ff.rho    <= side_ff[VEL_DIV_LAT-1][SIDE_W-1:DATA_W];
      b_cell_ff.energy <= side_ff[VEL_DIV_LAT-1][DATA_W-1:0];
   end

   assign out_valid = b_valid_ff;
   assign out_cell  = b_cell_ff;

endmodule

// ===== rtl/ctp_pressure.sv =====
module ctp_pressure (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   input  ctp_pkg::cell_type in_cell,
   input  ctp_pkg::csr_type  csr,
   output logic              out_valid,
   output ctp_pkg::prim_type out_prim
);
   import ctp_pkg::*;

   localparam int SPLIT_W = SQ_W / 2;
   localparam int PP_W    = RHO_W + SPLIT_W;
   localparam int KE_W    = RHO_W + SQ_W + 1;
   localparam int PM_W    = RHO_W + GAMMA_W;

   logic [2:0][DATA_W-1:0]   mag_w;
   logic [2:0][2*DATA_W-1:0] sqp_w;
   logic [KE_W-1:0]          kep_w;
   logic [KE_W-1:0]          kes_w;
   logic [DATA_W+1:0]        diff_w;
   logic [GAMMA_W-1:0]       gm1_w;
   logic [PM_W-FRAC_W-1:0]   pq_w;
   logic [RHO_W-1:0]         psat_w;

   logic                     c_valid_ff, d_valid_ff, e_valid_ff, f_valid_ff;
   logic                     g_valid_ff, h_valid_ff, i_valid_ff;
   cell_type                 c_cell_ff, d_cell_ff, e_cell_ff, f_cell_ff;
   cell_type                 g_cell_ff, h_cell_ff;
   logic [2:0][SQ_W-1:0]     c_sq_ff;
   logic [SQ_W-1:0]          d_sum_ff;
   logic [PP_W-1:0]          e_hi_ff, e_lo_ff;
   logic [DATA_W-1:0]        f_ke_ff;
   logic [RHO_W-1:0]         g_eint_ff;
   logic [DEN_W-1:0]         g_den_ff, h_den_ff;
   logic [PM_W-1:0]          h_pm_ff;
   prim_type                 i_prim_ff;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         mag_w[i] = in_cell.vel[i][DATA_W-1] ? (~in_cell.vel[i] + DATA_W'(1))
                                              : in_cell.vel[i];
         sqp_w[i] = (2*DATA_W)'(mag_w[i]) * (2*DATA_W)'(mag_w[i]);
      end
   end

   assign kep_w  = {e_hi_ff, {SPLIT_W{1'b0}}} + KE_W'(e_lo_ff);
   assign kes_w  = kep_w >> (FRAC_W + 1);
   assign diff_w = {{2{f_cell_ff.energy[DATA_W-1]}}, f_cell_ff.energy} - {2'b00, f_ke_ff};
   assign gm1_w  = (csr.gamma > ONE_Q) ? (csr.gamma - ONE_Q) : '0;
   assign pq_w   = h_pm_ff[PM_W-1:FRAC_W];
   assign psat_w = (pq_w > (PM_W-FRAC_W)'(SMAX)) ? SMAX : pq_w[RHO_W-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         c_valid_ff <= 1'b0;
         d_valid_ff <= 1'b0;
         e_valid_ff <= 1'b0;
         f_valid_ff <= 1'b0;
         g_valid_ff <= 1'b0;
         h_valid_ff <= 1'b0;
         i_valid_ff <= 1'b0;
      end else begin
         c_valid_ff <= in_valid;
         d_valid_ff <= c_valid_ff;
         e_valid_ff <= d_valid_ff;
         f_valid_ff <= e_valid_ff;
         g_valid_ff <= f_valid_ff;
         h_valid_ff <= g_valid_ff;
         i_valid_ff <= h_valid_ff;
      end
      c_cell_ff <= in_cell;
      for (int i = 0; i < 3; i++) begin
         c_sq_ff[i] <= sqp_w[i][FRAC_W+SQ_W-1:FRAC_W];
      end
      d_cell_ff <= c_cell_ff;
      d_sum_ff  <= c_sq_ff[0] + c_sq_ff[1] + c_sq_ff[2];
      e_cell_ff <= d_cell_ff;
      e_hi_ff   <= PP_W'(d_cell_ff.rho) * PP_W'(d_sum_ff[SQ_W-1:SPLIT_W]);
      e_lo_ff   <= PP_W'(d_cell_ff.rho) * PP_W'(d_sum_ff[SPLIT_W-1:0]);
      f_cell_ff <= e_cell_ff;
      f_ke_ff   <= (kes_w > KE_W'({1'b1, {RHO_W{1'b0}}})) ? {1'b1, {RHO_W{1'b0}}}
                                                          : kes_w[DATA_W-1:0];
      g_cell_ff <= f_cell_ff;
      g_eint_ff <= diff_w[DATA_W+1] ? '0 : diff_w[RHO_W-1:0];
      g_den_ff  <= DEN_W'(f_cell_ff.rho) * DEN_W'(csr.coef);
      h_cell_ff <= g_cell_ff;
      h_den_ff  <= g_den_ff;
      h_pm_ff   <= PM_W'(g_eint_ff) * PM_W'(gm1_w);
      i_prim_ff.vel      <= h_cell_ff.vel;
      i_prim_ff.den      <= h_den_ff;
      i_prim_ff.pressure <= (psat_w < RHO_W'(csr.pfloor)) ? RHO_W'(csr.pfloor) : psat_w;
   end

   assign out_valid = i_valid_ff;
   assign out_prim  = i_prim_ff;

endmodule
